// ----- sv/gdfo_pkg.sv -----
// ----------------------------------------------------------------------------
// gdfo_pkg
// Shared constants, types and the lowest-set-bit search used by the
// depth-first order block.
// ----------------------------------------------------------------------------
package gdfo_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int FIELD_CAP    = 32;
  localparam int VERTEX_CAP   = (MAX_VERTICES < FIELD_CAP) ? MAX_VERTICES : FIELD_CAP;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VERTEX_W     = 5;
  localparam int COUNT_W      = 6;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(32);

  localparam logic KIND_ADD      = 1'b0;
  localparam logic KIND_TRAVERSE = 1'b1;

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_RESTART,
    ST_EXPAND,
    ST_POP_WAIT
  } walk_state_t;

  // adjacency memory request
  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    row_t wr_data;
  } adj_req_t;

  // walk stack request
  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    idx_t wr_data;
  } stk_req_t;

  typedef struct packed {
    logic found;
    idx_t idx;
  } bit_pos_t;

  function automatic bit_pos_t lowest_bit(input row_t bits);
    bit_pos_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (bits[i]) begin
        res.found = 1'b1;
        res.idx   = IDX_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// ----- sv/gdfo_adj_mem.sv -----
// ----------------------------------------------------------------------------
// gdfo_adj_mem
// Adjacency bit matrix, one row per source vertex. Row valid bits cleared at
// reset make an unwritten row read as all zero.
// ----------------------------------------------------------------------------
module gdfo_adj_mem (
  input  logic              clk,
  input  logic              rst,
  input  gdfo_pkg::adj_req_t req,
  output gdfo_pkg::row_t    rd_row
);

  gdfo_pkg::row_t mem [gdfo_pkg::MAX_VERTICES];
  logic [gdfo_pkg::MAX_VERTICES-1:0] row_valid;
  gdfo_pkg::row_t rd_data;
  logic           rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= row_valid[req.rd_addr];
      end
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

// ----- sv/gdfo_stack_mem.sv -----
// ----------------------------------------------------------------------------
// gdfo_stack_mem
// Walk stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gdfo_stack_mem (
  input  logic               clk,
  input  gdfo_pkg::stk_req_t req,
  output gdfo_pkg::idx_t     rd_data
);

  gdfo_pkg::idx_t mem [gdfo_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ----- sv/graph_depth_first_order.sv -----
// ----------------------------------------------------------------------------
// graph_depth_first_order
// Depth-first preorder of a small directed graph held as a bit matrix.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): kind 0 adds the edge src_vertex ->
// dst_vertex, kind 1 runs a traversal. An add reads the source row from the
// adjacency memory, then writes it back with the new bit set.
// Edges naming a vertex at or beyond vertex_count are dropped.
// A traversal emits one word per vertex in use on the output channel
// (out_valid / out_stall), visited_vertex in depth-first order and last set
// on the final word. Each vertex costs one push, its row read overlapping the
// next step, and each backtrack reads the entry below from the walk stack unless
// the stack empties, so a walk is paced by the adjacency memory reads and the
// registered read of the stack.
// in_stall stays high until the walk or the write-back finishes.
// A stalled output word holds; the walk pauses at the next emission until
// the output register frees up.
// Configuration (cfg_valid / cfg_ready / cfg_data) writes vertex_count; write
// it only while idle. Reset clears the matrix and sets vertex_count to 32.
// ----------------------------------------------------------------------------
module graph_depth_first_order (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [4:0] src_vertex,
  input  logic [4:0] dst_vertex,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] visited_vertex,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  gdfo_pkg::walk_state_t state, state_next;

  logic [gdfo_pkg::COUNT_W-1:0] vertex_count;
  gdfo_pkg::cnt_t  n_act;
  gdfo_pkg::row_t  used;
  gdfo_pkg::row_t  visited, visited_next;
  gdfo_pkg::cnt_t  depth, depth_next;
  gdfo_pkg::cnt_t  emitted, emitted_next;
  gdfo_pkg::idx_t  add_src, add_dst;
  gdfo_pkg::row_t  adj_row;
  gdfo_pkg::idx_t  stk_top;
  gdfo_pkg::adj_req_t adj_req;
  gdfo_pkg::stk_req_t stk_req;
  gdfo_pkg::row_t  search_in;
  gdfo_pkg::bit_pos_t hit;
  logic            emit_ok;
  logic            emit;
  gdfo_pkg::idx_t  emit_idx;
  logic            emit_last;
  logic            edge_ok;

  gdfo_adj_mem u_adj (
    .clk    (clk),
    .rst    (rst),
    .req    (adj_req),
    .rd_row (adj_row)
  );

  gdfo_stack_mem u_stack (
    .clk     (clk),
    .req     (stk_req),
    .rd_data (stk_top)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gdfo_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // saturate the count to what the matrix and the result field can name
  always_comb begin
    if (gdfo_pkg::COUNT_W'(vertex_count) > gdfo_pkg::COUNT_W'(gdfo_pkg::VERTEX_CAP)) begin
      n_act = gdfo_pkg::CNT_W'(gdfo_pkg::VERTEX_CAP);
    end else begin
      n_act = gdfo_pkg::CNT_W'(vertex_count);
    end
    for (int i = 0; i < gdfo_pkg::MAX_VERTICES; i++) begin
      used[i] = gdfo_pkg::CNT_W'(i) < n_act;
    end
  end

  assign in_stall = (state != gdfo_pkg::ST_IDLE);
  assign emit_ok  = !out_valid || !out_stall;
  assign edge_ok  = ({1'b0, src_vertex} < 6'(n_act)) && ({1'b0, dst_vertex} < 6'(n_act));

  assign search_in = (state == gdfo_pkg::ST_RESTART) ? (~visited & used)
                                                     : (adj_row & ~visited & used);
  assign hit = gdfo_pkg::lowest_bit(search_in);

  always_comb begin
    state_next   = state;
    visited_next = visited;
    depth_next   = depth;
    emitted_next = emitted;
    emit         = 1'b0;
    emit_idx     = hit.idx;
    emit_last    = (emitted + gdfo_pkg::CNT_W'(1)) == n_act;
    adj_req      = '0;
    stk_req      = '0;

    unique case (state)
      gdfo_pkg::ST_IDLE: begin
        // start the row read at accept so the write-back lands next cycle
        adj_req.rd_en   = in_valid && (kind == gdfo_pkg::KIND_ADD);
        adj_req.rd_addr = gdfo_pkg::IDX_W'(src_vertex);
        if (in_valid) begin
          if (kind == gdfo_pkg::KIND_ADD) begin
            if (edge_ok) begin
              state_next = gdfo_pkg::ST_ADD_WR;
            end
          end else begin
            visited_next = '0;
            depth_next   = '0;
            emitted_next = '0;
            if (n_act != '0) begin
              state_next = gdfo_pkg::ST_RESTART;
            end
          end
        end
      end

      gdfo_pkg::ST_ADD_WR: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = add_src;
        adj_req.wr_data = adj_row | (gdfo_pkg::row_t'(1) << add_dst);
        state_next      = gdfo_pkg::ST_IDLE;
      end

      gdfo_pkg::ST_RESTART, gdfo_pkg::ST_EXPAND: begin
        if (hit.found && (depth < gdfo_pkg::CNT_W'(gdfo_pkg::MAX_VERTICES))) begin
          // push the next vertex once the output slot frees up
          if (emit_ok) begin
            emit             = 1'b1;
            visited_next     = visited | (gdfo_pkg::row_t'(1) << hit.idx);
            depth_next       = depth + gdfo_pkg::CNT_W'(1);
            emitted_next     = emitted + gdfo_pkg::CNT_W'(1);
            stk_req.wr_en    = 1'b1;
            stk_req.wr_addr  = depth[gdfo_pkg::IDX_W-1:0];
            stk_req.wr_data  = hit.idx;
            adj_req.rd_en    = 1'b1;
            adj_req.rd_addr  = hit.idx;
            state_next       = emit_last ? gdfo_pkg::ST_IDLE : gdfo_pkg::ST_EXPAND;
          end
        end else if (state == gdfo_pkg::ST_EXPAND) begin
          // backtrack: drop the top, fetch the entry below it if there is one
          depth_next = depth - gdfo_pkg::CNT_W'(1);
          if (depth == gdfo_pkg::CNT_W'(1)) begin
            state_next = gdfo_pkg::ST_RESTART;
          end else begin
            stk_req.rd_en   = 1'b1;
            stk_req.rd_addr = gdfo_pkg::IDX_W'(depth - gdfo_pkg::CNT_W'(2));
            state_next      = gdfo_pkg::ST_POP_WAIT;
          end
        end else begin
          state_next = gdfo_pkg::ST_IDLE;
        end
      end

      gdfo_pkg::ST_POP_WAIT: begin
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = stk_top;
        state_next      = gdfo_pkg::ST_EXPAND;
      end

      default: begin
        state_next = gdfo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gdfo_pkg::ST_IDLE;
      visited <= '0;
      depth   <= '0;
      emitted <= '0;
    end else begin
      state   <= state_next;
      visited <= visited_next;
      depth   <= depth_next;
      emitted <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gdfo_pkg::ST_IDLE && in_valid) begin
      add_src <= gdfo_pkg::IDX_W'(src_vertex);
      add_dst <= gdfo_pkg::IDX_W'(dst_vertex);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      visited_vertex <= gdfo_pkg::VERTEX_W'(emit_idx);
      last           <= emit_last;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= gdfo_pkg::CNT_W'(gdfo_pkg::MAX_VERTICES))
    else $error("walk stack depth beyond capacity");

  a_expand_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == gdfo_pkg::ST_EXPAND || state == gdfo_pkg::ST_POP_WAIT) |-> depth != '0)
    else $error("expanding with an empty stack");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == gdfo_pkg::ST_RESTART || state == gdfo_pkg::ST_EXPAND) |-> emitted < n_act)
    else $error("walk running after all vertices emitted");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> (state == gdfo_pkg::ST_IDLE && out_valid && last))
    else $error("final word did not end the walk");

endmodule
